// File: rtl/core/sssp_pkg.sv
package sssp_pkg;

    localparam int MAX_NODES   = 64;
    localparam int NODE_BITS   = $clog2(MAX_NODES);
    localparam int COUNT_BITS  = $clog2(MAX_NODES + 1);
    localparam int MAX_EDGES   = 1024;
    localparam int EADDR_BITS  = $clog2(MAX_EDGES);
    localparam int ECNT_BITS   = $clog2(MAX_EDGES + 1);
    localparam int WEIGHT_BITS = 16;
    localparam int DIST_BITS   = 24;
    localparam int EDGE_BITS   = 2 * NODE_BITS + WEIGHT_BITS;
    localparam int CFG_BITS    = 7;

    localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

    typedef enum logic [0:0] {
        REG_START_NODE = 1'b0,
        REG_NODE_COUNT = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic load;
        logic init;
        logic pass_start;
        logic erd;
        logic drd;
        logic relax;
        logic ord;
        logic oload;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic pass_end;
        logic changed;
        logic last_node;
        logic out_free;
    } t_sts;

endpackage

// File: rtl/core/sssp_if.sv
interface sssp_in_if;
    logic                                valid;
    logic                                ready;
    logic [sssp_pkg::NODE_BITS-1:0]      from_node;
    logic [sssp_pkg::NODE_BITS-1:0]      to_node;
    logic [sssp_pkg::WEIGHT_BITS-1:0]    edge_weight;
    logic                                last_edge;
    modport source (output valid, from_node, to_node, edge_weight, last_edge, input ready);
    modport sink (input valid, from_node, to_node, edge_weight, last_edge, output ready);
endinterface

interface sssp_out_if;
    logic                                valid;
    logic                                ready;
    logic [sssp_pkg::NODE_BITS-1:0]      node_index;
    logic [sssp_pkg::DIST_BITS-1:0]      distance;
    logic                                reachable;
    logic                                last_result;
    logic                                edge_overflow;
    modport source (output valid, node_index, distance, reachable, last_result,
                    edge_overflow, input ready);
    modport sink (input valid, node_index, distance, reachable, last_result,
                  edge_overflow, output ready);
endinterface

// File: rtl/core/single_source_shortest_path_top.sv
// Channel   Dir  Fields                                             Note
// i_edge    in   from_node, to_node, edge_weight, last_edge         one edge per item
// o_res     out  node_index, distance, reachable, last_result,      node_count items
//                edge_overflow                                      per graph
// cfg       in   i_cfg_we, i_cfg_idx, i_cfg_data                    start_node, node_count
//
// Edges load at one item per cycle into the edge memory.
// After the last edge, an init state, then relaxation passes in which each edge goes
// through edge read, distance read and relax states, until a pass changes no distance;
// input ready stays low meanwhile.
// Results then leave one at a time, held by the output register under stall.
// Reset clears counters, valid bits and control; no clearing pass is needed.
module single_source_shortest_path_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [sssp_pkg::CFG_BITS-1:0] i_cfg_data,
    sssp_in_if.sink                       i_edge,
    sssp_out_if.source                    o_res
);

    sssp_pkg::t_cmd cmd;
    sssp_pkg::t_sts sts;

    sssp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_edge.valid),
        .i_in_last  (i_edge.last_edge),
        .o_in_ready (i_edge.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    sssp_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_from_node   (i_edge.from_node),
        .i_to_node     (i_edge.to_node),
        .i_edge_weight (i_edge.edge_weight),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .out_if        (o_res)
    );

endmodule

// File: rtl/core/sssp_ctrl.sv
module sssp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_last,
    output logic           o_in_ready,
    input  sssp_pkg::t_sts i_sts,
    output sssp_pkg::t_cmd o_cmd
);

    typedef enum logic [6:0] {
        S_LOAD  = 7'b0000001,
        S_INIT  = 7'b0000010,
        S_ERD   = 7'b0000100,
        S_DRD   = 7'b0001000,
        S_RELAX = 7'b0010000,
        S_ORD   = 7'b0100000,
        S_OWAIT = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_LOAD);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_LOAD: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_in_last) begin
                        n_state = S_INIT;
                    end
                end
            end
            S_INIT: begin
                o_cmd.init       = 1'b1;
                o_cmd.pass_start = 1'b1;
                n_state          = S_ERD;
            end
            S_ERD: begin
                o_cmd.erd = 1'b1;
                n_state   = S_DRD;
            end
            S_DRD: begin
                o_cmd.drd = 1'b1;
                n_state   = S_RELAX;
            end
            S_RELAX: begin
                o_cmd.relax = 1'b1;
                if (!i_sts.pass_end) begin
                    n_state = S_ERD;
                end else if (i_sts.changed) begin
                    o_cmd.pass_start = 1'b1;
                    n_state          = S_ERD;
                end else begin
                    n_state = S_ORD;
                end
            end
            S_ORD: begin
                o_cmd.ord = 1'b1;
                n_state   = S_OWAIT;
            end
            S_OWAIT: begin
                if (i_sts.out_free) begin
                    o_cmd.oload = 1'b1;
                    if (i_sts.last_node) begin
                        o_cmd.finish = 1'b1;
                        n_state      = S_LOAD;
                    end else begin
                        n_state = S_ORD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

endmodule

// File: rtl/core/sssp_dp.sv
module sssp_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_idx,
    input  logic [sssp_pkg::CFG_BITS-1:0]      i_cfg_data,
    input  logic [sssp_pkg::NODE_BITS-1:0]     i_from_node,
    input  logic [sssp_pkg::NODE_BITS-1:0]     i_to_node,
    input  logic [sssp_pkg::WEIGHT_BITS-1:0]   i_edge_weight,
    input  sssp_pkg::t_cmd                     i_cmd,
    output sssp_pkg::t_sts                     o_sts,
    sssp_out_if.source                         out_if
);

    localparam int NB = sssp_pkg::NODE_BITS;
    localparam int CB = sssp_pkg::COUNT_BITS;
    localparam int DB = sssp_pkg::DIST_BITS;
    localparam int WB = sssp_pkg::WEIGHT_BITS;
    localparam int EB = sssp_pkg::ECNT_BITS;
    localparam int AB = sssp_pkg::EADDR_BITS;
    localparam int NN = sssp_pkg::MAX_NODES;

    logic [NB-1:0] r_start;
    logic [CB-1:0] r_ncount;
    logic [CB-1:0] n_eff;

    logic [sssp_pkg::EDGE_BITS-1:0] r_emem [sssp_pkg::MAX_EDGES];
    logic [sssp_pkg::EDGE_BITS-1:0] r_eq;
    logic [DB-1:0]                  r_dmem [sssp_pkg::MAX_NODES];
    logic [DB-1:0]                  r_dsrc;
    logic [DB-1:0]                  r_ddst;
    logic [sssp_pkg::MAX_NODES-1:0] r_vld;

    logic [EB-1:0] r_ecnt;
    logic [AB-1:0] r_eidx;
    logic          r_drop;
    logic          r_changed;
    logic [NB-1:0] r_node;
    logic [NB-1:0] r_esrc;
    logic [NB-1:0] r_edst;
    logic [WB-1:0] r_ew;

    logic          r_ovalid;
    logic          start_ok;
    logic          relax_ok;
    logic [DB:0]   sum;
    logic [DB-1:0] cand;
    logic          upd;
    logic          dwe;
    logic [NB-1:0] dwa;
    logic [DB-1:0] dwd;

    always_comb begin
        if (r_ncount == '0) begin
            n_eff = CB'(1);
        end else if (r_ncount > CB'(sssp_pkg::MAX_NODES)) begin
            n_eff = CB'(sssp_pkg::MAX_NODES);
        end else begin
            n_eff = r_ncount;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start  <= '0;
            r_ncount <= CB'(sssp_pkg::MAX_NODES);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sssp_pkg::REG_START_NODE: r_start  <= i_cfg_data[NB-1:0];
                sssp_pkg::REG_NODE_COUNT: r_ncount <= i_cfg_data[CB-1:0];
                default: ;
            endcase
        end
    end

    // edge store
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && r_ecnt < EB'(sssp_pkg::MAX_EDGES)) begin
            r_emem[r_ecnt[AB-1:0]] <= {i_from_node, i_to_node, i_edge_weight};
        end
        if (i_cmd.erd) begin
            r_eq <= r_emem[r_eidx];
        end
    end

    assign start_ok = {1'b0, r_start} < n_eff;
    assign relax_ok = ({1'b0, r_esrc} < n_eff) && ({1'b0, r_edst} < n_eff) && r_vld[r_esrc];
    assign sum      = {1'b0, r_dsrc} + (DB+1)'(r_ew);
    assign cand     = sum[DB] ? sssp_pkg::DIST_MAX : sum[DB-1:0];
    assign upd      = i_cmd.relax && relax_ok && (!r_vld[r_edst] || r_ddst > cand);

    always_comb begin
        dwe = 1'b0;
        dwa = r_edst;
        dwd = cand;
        if (i_cmd.init) begin
            dwe = start_ok;
            dwa = r_start;
            dwd = '0;
        end else if (upd) begin
            dwe = 1'b1;
        end
    end

    // distance store, two read ports
    always_ff @(posedge i_clk) begin
        if (dwe) begin
            r_dmem[dwa] <= dwd;
        end
        if (i_cmd.drd) begin
            r_dsrc <= r_dmem[r_eq[sssp_pkg::EDGE_BITS-1 -: NB]];
            r_ddst <= r_dmem[r_eq[WB +: NB]];
        end else if (i_cmd.ord) begin
            r_dsrc <= r_dmem[r_node];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.drd) begin
            r_esrc <= r_eq[sssp_pkg::EDGE_BITS-1 -: NB];
            r_edst <= r_eq[WB +: NB];
            r_ew   <= r_eq[WB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_ecnt    <= '0;
            r_drop    <= 1'b0;
            r_eidx    <= '0;
            r_changed <= 1'b0;
            r_node    <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                if (r_ecnt < EB'(sssp_pkg::MAX_EDGES)) begin
                    r_ecnt <= r_ecnt + EB'(1);
                end else begin
                    r_drop <= 1'b1;
                end
            end
            if (i_cmd.init) begin
                r_vld <= start_ok ? (NN'(1) << r_start) : '0;
            end else if (upd) begin
                r_vld[r_edst] <= 1'b1;
            end
            if (i_cmd.pass_start) begin
                r_eidx    <= '0;
                r_changed <= 1'b0;
            end else if (i_cmd.relax) begin
                r_eidx <= r_eidx + AB'(1);
                if (upd) begin
                    r_changed <= 1'b1;
                end
            end
            if (i_cmd.oload) begin
                r_ovalid <= 1'b1;
            end else if (out_if.valid && out_if.ready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cmd.finish) begin
                r_node <= '0;
                r_ecnt <= '0;
                r_drop <= 1'b0;
            end else if (i_cmd.oload) begin
                r_node <= r_node + NB'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.oload) begin
            out_if.node_index    <= r_node;
            out_if.distance      <= r_vld[r_node] ? r_dsrc : '0;
            out_if.reachable     <= r_vld[r_node];
            out_if.last_result   <= o_sts.last_node;
            out_if.edge_overflow <= r_drop;
        end
    end

    assign out_if.valid    = r_ovalid;
    assign o_sts.pass_end  = ({1'b0, r_eidx} + EB'(1)) == r_ecnt;
    assign o_sts.changed   = r_changed || upd;
    assign o_sts.last_node = ({1'b0, r_node} + CB'(1)) == n_eff;
    assign o_sts.out_free  = !r_ovalid || out_if.ready;

endmodule

// File: tb/tb_single_source_shortest_path_top.sv
module tb_single_source_shortest_path_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NB = sssp_pkg::NODE_BITS;
    localparam int WB = sssp_pkg::WEIGHT_BITS;
    localparam int DB = sssp_pkg::DIST_BITS;
    localparam int CB = sssp_pkg::CFG_BITS;
    localparam int NN = sssp_pkg::MAX_NODES;
    localparam int NE = sssp_pkg::MAX_EDGES;
    localparam int WATCH_LIMIT = 1000000;

    typedef struct packed {
        logic [NB-1:0] from_node;
        logic [NB-1:0] to_node;
        logic [WB-1:0] edge_weight;
        logic          last_edge;
    } t_edge;

    typedef struct packed {
        logic [NB-1:0] node_index;
        logic [DB-1:0] distance;
        logic          reachable;
        logic          last_result;
        logic          edge_overflow;
    } t_res;

    typedef struct {
        int    cfg_start;
        int    cfg_count;
        t_edge e;
        bit    has_exp;
        t_res  exp_res;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic i_cfg_idx = 1'b0;
    logic [CB-1:0] i_cfg_data = '0;

    sssp_in_if  edge_ch ();
    sssp_out_if res_ch ();

    single_source_shortest_path_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_edge     (edge_ch.sink),
        .o_res      (res_ch.source)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [NB-1:0] g_src [NE];
    logic [NB-1:0] g_dst [NE];
    logic [WB-1:0] g_len [NE];
    int  g_edges;
    bit  g_dropped;
    int  m_start;
    int  m_count;

    t_res expected_q [$];
    int   fail_count;
    int   quiet_cycles = 0;
    int   send_idle_pct;
    int   recv_idle_pct;
    bit   recv_hold;

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic compute_distances();
        longint node_dist [NN];
        bit     done [NN];
        int n, u, v;
        longint best, cand;
        t_res r;
        n = (m_count == 0) ? 1 : (m_count > NN ? NN : m_count);
        for (int i = 0; i < NN; i++) begin
            node_dist[i] = -1;
            done[i] = 0;
        end
        if (m_start < n)
            node_dist[m_start] = 0;
        forever begin
            u = -1;
            best = 0;
            for (int i = 0; i < n; i++)
                if (!done[i] && node_dist[i] >= 0 && (u < 0 || node_dist[i] < best)) begin
                    u = i;
                    best = node_dist[i];
                end
            if (u < 0)
                break;
            done[u] = 1;
            for (int e = 0; e < g_edges; e++) begin
                if (g_src[e] != u)
                    continue;
                v = g_dst[e];
                if (v >= n)
                    continue;
                cand = node_dist[u] + g_len[e];
                if (cand > sssp_pkg::DIST_MAX)
                    cand = sssp_pkg::DIST_MAX;
                if (node_dist[v] < 0 || node_dist[v] > cand)
                    node_dist[v] = cand;
            end
        end
        for (int i = 0; i < n; i++) begin
            r.node_index    = NB'(i);
            r.reachable     = node_dist[i] >= 0;
            r.distance      = (node_dist[i] >= 0) ? node_dist[i][DB-1:0] : '0;
            r.last_result   = (i + 1 == n);
            r.edge_overflow = g_dropped;
            expected_q.push_back(r);
        end
        g_edges = 0;
        g_dropped = 0;
    endtask

    task automatic predict_edge(input t_edge e);
        if (g_edges < NE) begin
            g_src[g_edges] = e.from_node;
            g_dst[g_edges] = e.to_node;
            g_len[g_edges] = e.edge_weight;
            g_edges++;
        end else begin
            g_dropped = 1;
        end
        if (e.last_edge)
            compute_distances();
    endtask

    task automatic write_reg(input sssp_pkg::t_reg_idx idx, input int value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CB'(value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == sssp_pkg::REG_START_NODE)
            m_start = value & 63;
        else
            m_count = value & 127;
    endtask

    task automatic send_edge(input t_edge e);
        while ($urandom_range(99) < send_idle_pct) begin
            edge_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        edge_ch.valid       <= 1'b1;
        edge_ch.from_node   <= e.from_node;
        edge_ch.to_node     <= e.to_node;
        edge_ch.edge_weight <= e.edge_weight;
        edge_ch.last_edge   <= e.last_edge;
        do @(posedge i_clk); while (!edge_ch.ready);
        predict_edge(e);
    endtask

    task automatic drain();
        edge_ch.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic t_edge rand_edge(input int nodes, input int wmax, input bit last);
        t_edge e;
        e.from_node   = NB'($urandom_range(nodes - 1));
        e.to_node     = NB'($urandom_range(nodes - 1));
        e.edge_weight = WB'($urandom_range(wmax));
        e.last_edge   = last;
        return e;
    endfunction

    function automatic t_res mk_res(input int idx, input int d, input bit reach,
                                    input bit last, input bit ovf);
        t_res x;
        x.node_index    = NB'(idx);
        x.distance      = DB'(d);
        x.reachable     = reach;
        x.last_result   = last;
        x.edge_overflow = ovf;
        return x;
    endfunction

    function automatic t_row mk_row(input int cfg_start, input int cfg_count, input int f,
                                    input int t, input int w, input bit last,
                                    input bit has_exp, input t_res x);
        t_row row;
        row.cfg_start       = cfg_start;
        row.cfg_count       = cfg_count;
        row.e.from_node     = NB'(f);
        row.e.to_node       = NB'(t);
        row.e.edge_weight   = WB'(w);
        row.e.last_edge     = last;
        row.has_exp         = has_exp;
        row.exp_res         = x;
        return row;
    endfunction

    // receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
            if (res_ch.valid && res_ch.ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("result with none expected");
                end else begin
                    t_res x;
                    x = expected_q.pop_front();
                    if (res_ch.node_index !== x.node_index)
                        report_mismatch($sformatf("node_index %0d exp %0d",
                            res_ch.node_index, x.node_index));
                    if (res_ch.distance !== x.distance)
                        report_mismatch($sformatf("node %0d distance %0d exp %0d",
                            x.node_index, res_ch.distance, x.distance));
                    if (res_ch.reachable !== x.reachable)
                        report_mismatch($sformatf("node %0d reachable %0b exp %0b",
                            x.node_index, res_ch.reachable, x.reachable));
                    if (res_ch.last_result !== x.last_result)
                        report_mismatch($sformatf("node %0d last_result %0b exp %0b",
                            x.node_index, res_ch.last_result, x.last_result));
                    if (res_ch.edge_overflow !== x.edge_overflow)
                        report_mismatch($sformatf("node %0d edge_overflow %0b exp %0b",
                            x.node_index, res_ch.edge_overflow, x.edge_overflow));
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((edge_ch.valid && edge_ch.ready) || (res_ch.valid && res_ch.ready)
                || !i_rst_n || recv_hold)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCH_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // long receiver hold-off while edges keep flowing
    task automatic hold_receiver();
        int n;
        n = 0;
        recv_hold = 1;
        while (n < 3000) begin
            @(posedge i_clk);
            n++;
        end
        recv_hold = 0;
    endtask

    initial begin
        t_row rows [$];
        t_edge e;
        t_res no_res;
        int sent, gsize, nodes, wmax, phase, reps;
        bit held, new_graph;

        edge_ch.valid       = 1'b0;
        edge_ch.from_node   = '0;
        edge_ch.to_node     = '0;
        edge_ch.edge_weight = '0;
        edge_ch.last_edge   = 1'b0;
        recv_hold = 0;
        fail_count = 0;
        send_idle_pct = 24;
        recv_idle_pct = 62;
        g_edges = 0;
        g_dropped = 0;
        m_start = 0;
        m_count = NN;
        no_res = '0;
        held = 0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // node_count 1, single self loop, start 0 -> distance 0
        rows.push_back(mk_row(0, 1, 0, 0, 65535, 1'b1, 1'b1,
                              mk_res(0, 0, 1'b1, 1'b1, 1'b0)));
        // long chain at max weight over 64 nodes, start 63
        rows.push_back(mk_row(63, 64, 63, 62, 65535, 1'b0, 1'b0, no_res));
        for (int i = 62; i > 0; i -= 8)
            rows.push_back(mk_row(63, 64, i, (i < 8) ? 0 : i - 8, 65535, 1'b0, 1'b0,
                                  no_res));
        rows.push_back(mk_row(63, 64, 62, 54, 65535, 1'b0, 1'b0, no_res));
        rows.push_back(mk_row(63, 64, 54, 0, 0, 1'b0, 1'b0, no_res));
        rows.push_back(mk_row(63, 64, 0, 21, 1, 1'b0, 1'b0, no_res));
        rows.push_back(mk_row(63, 64, 21, 42, 'h5555, 1'b0, 1'b0, no_res));
        rows.push_back(mk_row(63, 64, 42, 1, 'hAAAA, 1'b1, 1'b0, no_res));
        // start out of range: nothing reachable
        rows.push_back(mk_row(10, 4, 0, 1, 5, 1'b0, 1'b0, no_res));
        rows.push_back(mk_row(10, 4, 10, 2, 5, 1'b1, 1'b1,
                              mk_res(0, 0, 1'b0, 1'b0, 1'b0)));
        // node_count 0 taken as 1
        rows.push_back(mk_row(0, 0, 0, 5, 3, 1'b1, 1'b1,
                              mk_res(0, 0, 1'b1, 1'b1, 1'b0)));
        // node_count above max taken as max
        rows.push_back(mk_row(0, 127, 0, 63, 7, 1'b0, 1'b0, no_res));
        rows.push_back(mk_row(0, 127, 63, 3, 9, 1'b1, 1'b1,
                              mk_res(0, 0, 1'b1, 1'b0, 1'b0)));

        new_graph = 1'b1;
        foreach (rows[i]) begin
            if (new_graph) begin
                write_reg(sssp_pkg::REG_START_NODE, rows[i].cfg_start);
                write_reg(sssp_pkg::REG_NODE_COUNT, rows[i].cfg_count);
            end
            send_edge(rows[i].e);
            if (rows[i].has_exp
                    && (expected_q.size() == 0 || expected_q[0] !== rows[i].exp_res))
                report_mismatch($sformatf("directed row %0d expectation", i));
            new_graph = rows[i].e.last_edge;
            if (new_graph)
                drain();
        end

        // random graphs, three idle phases
        sent = 0;
        for (phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                send_idle_pct = 62;
                recv_idle_pct = 24;
            end else if (phase == 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            while (sent < (phase + 1) * 145) begin
                write_reg(sssp_pkg::REG_START_NODE, $urandom_range(63));
                case ($urandom_range(3))
                    0: nodes = 64;
                    1: nodes = 1;
                    default: nodes = $urandom_range(2, 12);
                endcase
                write_reg(sssp_pkg::REG_NODE_COUNT, $urandom_range(3) == 0 ? nodes :
                          $urandom_range(1, 16));
                wmax = ($urandom_range(3) == 0) ? 65535 : 30;
                gsize = $urandom_range(1, 14);
                reps = 1;
                if (phase == 1 && !held) begin
                    held = 1;
                    reps = 2;
                    fork
                        hold_receiver();
                    join_none
                end
                for (int g = 0; g < reps; g++)
                    for (int i = 0; i < gsize; i++) begin
                        e = rand_edge($urandom_range(4) == 0 ? 64 : 16, wmax,
                                      i == gsize - 1);
                        send_edge(e);
                        sent++;
                    end
                drain();
            end
        end

        drain();
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

// File: filelist.f
rtl/core/sssp_pkg.sv
rtl/core/sssp_if.sv
rtl/core/sssp_ctrl.sv
rtl/core/sssp_dp.sv
rtl/core/single_source_shortest_path_top.sv
tb/tb_single_source_shortest_path_top.sv
